@@ hdl/afu_pkg.sv @@
// Package for the audio frame FIFO upsampler: sizes, constants and pointer helpers.
// No dependencies; imported by the top level.
`default_nettype none

package afu_pkg;

    // Store and block sizes
    localparam int FIFO_FRAMES = 8192;
    localparam int OUT_BLOCK   = 256;
    localparam int SRC_BLOCK   = ((2 * (OUT_BLOCK - 1)) / 3) + 1;

    // Derived widths
    localparam int PTR_W = $clog2(FIFO_FRAMES);
    localparam int CNT_W = $clog2(FIFO_FRAMES + 1);
    localparam int PH_W  = $clog2(OUT_BLOCK);
    localparam int RES_W = $clog2(SRC_BLOCK + 1);
    localparam int SRC_W = $clog2(SRC_BLOCK);

    // Fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int FRAME_W  = 2 * SAMPLE_W;
    localparam int LIMIT_W  = 14;
    localparam int FBUF_W   = 14;

    localparam logic [LIMIT_W-1:0] RESET_LIMIT = LIMIT_W'(6000);

    // Command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Phase of the 2-to-3 step pattern
    typedef logic [1:0] ph3_t;
    localparam ph3_t PH3_0 = 2'd0;
    localparam ph3_t PH3_1 = 2'd1;
    localparam ph3_t PH3_2 = 2'd2;

    // Add an offset to a store pointer, wrapping at the store depth
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] a,
                                                 input logic [PTR_W-1:0] b);
        logic [PTR_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (PTR_W + 1)'(FIFO_FRAMES)) begin
            sum = sum - (PTR_W + 1)'(FIFO_FRAMES);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/afu_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module afu_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024
) (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [DATA_W-1:0]          wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [DATA_W-1:0]          rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/audio_frame_fifo_upsampler.sv @@
// Top level: stereo frame FIFO with a 2-to-3 nearest-neighbour upsampler.
// Depends on afu_pkg and afu_ram.
//
// Channel   Dir  Handshake           Payload
// s_        in   s_tvalid/s_tready   tdata: left, right; tuser: command, call_start
// m_        out  m_tvalid/m_tready   tdata: left, right, frames_buffered;
//                                    tuser: underrun, dropped; tlast: block_end
// cfg_      in   cfg_wr_en           cfg_wr_data: accept_limit
//
// One item per cycle unless m_tready stalls; each item is at most one access to the
// frame store. An item passes the registered store read and the output register
// before m_tvalid rises. Counters and pointers update in the accept cycle; a tick reads
// the store on a later edge than any earlier push wrote it, so no forwarding is needed.
// Reset (aresetn low, synchronous) empties the queue; the store is not cleared.
// A stall on m_tready holds the output and store read stages, then the input.
`default_nettype none

module audio_frame_fifo_upsampler
    import afu_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input items
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [31:0]          s_tdata,   // [15:0] sample_left, [31:16] sample_right
    input  wire logic [1:0]           s_tuser,   // [0] command, [1] call_start
    // Result items
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [47:0]               m_tdata,   // [15:0] out_left, [31:16] out_right,
                                                 // [45:32] frames_buffered, [47:46] zero
    output logic [1:0]                m_tuser,   // [0] underrun, [1] dropped
    output logic                      m_tlast,   // block_end
    // Configuration
    input  wire logic                 cfg_wr_en,
    input  wire logic [LIMIT_W-1:0]   cfg_wr_data
);

    typedef struct packed {
        logic              tick;
        logic              underrun;
        logic              block_end;
        logic              dropped;
        logic [FBUF_W-1:0] fbuf;
    } stage_t;

    // Control state
    logic [LIMIT_W-1:0] limit_reg;
    logic [PTR_W-1:0]   wr_ptr_reg,   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg,   rd_ptr_next;
    logic [CNT_W-1:0]   queued_reg,   queued_next;
    logic [RES_W-1:0]   reserved_reg, reserved_next;
    logic [PTR_W-1:0]   base_reg,     base_next;
    logic [PH_W-1:0]    phase_reg,    phase_next;
    logic [SRC_W-1:0]   src_reg,      src_next;
    ph3_t               ph3_reg,      ph3_next;
    logic               acc_reg,      acc_next;

    // Pipeline
    logic   st_valid_reg;
    stage_t st_reg, st_next;
    logic   m_valid_reg;
    logic [SAMPLE_W-1:0] m_left_reg, m_right_reg;
    logic [FBUF_W-1:0]   m_fbuf_reg;
    logic                m_under_reg, m_drop_reg, m_end_reg;

    // Store ports
    logic               ram_wr_en, ram_rd_en;
    logic [PTR_W-1:0]   ram_rd_addr;
    logic [FRAME_W-1:0] ram_rd_data;

    logic in_fire, st_adv;
    logic cmd, call_start;

    // Work per item
    logic               acc_eff;
    logic [RES_W-1:0]   take_n;
    logic [RES_W-1:0]   reserved_eff;
    logic [PTR_W-1:0]   base_eff;
    logic               full;

    assign cmd        = s_tuser[0];
    assign call_start = s_tuser[1];

    // Advance the store stage when the output register is free or drains
    assign st_adv   = st_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !st_valid_reg || st_adv;
    assign in_fire  = s_tvalid && s_tready;

    // Work out the next queue and block state for the accepted item
    always_comb begin
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        queued_next   = queued_reg;
        reserved_next = reserved_reg;
        base_next     = base_reg;
        phase_next    = phase_reg;
        src_next      = src_reg;
        ph3_next      = ph3_reg;
        acc_next      = acc_reg;
        ram_wr_en     = 1'b0;
        ram_rd_en     = 1'b0;
        st_next       = '0;
        acc_eff       = acc_reg;
        full          = 1'b0;
        take_n        = '0;
        reserved_eff  = reserved_reg;
        base_eff      = base_reg;
        ram_rd_addr   = '0;

        if (in_fire) begin
            if (cmd == CMD_PUSH) begin
                // Decide the call at its first frame, then drop or store
                if (call_start) begin
                    acc_eff = (32'(queued_reg) < 32'(limit_reg));
                end
                acc_next = acc_eff;
                full = (32'(queued_reg) + 32'(reserved_reg) >= 32'(FIFO_FRAMES));
                if (!acc_eff || full) begin
                    st_next.dropped = 1'b1;
                end else begin
                    ram_wr_en   = 1'b1;
                    wr_ptr_next = ptr_add(wr_ptr_reg, PTR_W'(1));
                    queued_next = queued_reg + CNT_W'(1);
                end
            end else begin
                // Reserve source frames at the start of a block
                st_next.tick = 1'b1;
                if (phase_reg == '0) begin
                    if (32'(queued_reg) < 32'(SRC_BLOCK)) begin
                        take_n = RES_W'(queued_reg);
                    end else begin
                        take_n = RES_W'(SRC_BLOCK);
                    end
                    base_eff     = rd_ptr_reg;
                    reserved_eff = take_n;
                    rd_ptr_next  = ptr_add(rd_ptr_reg, PTR_W'(take_n));
                    queued_next  = queued_reg - CNT_W'(take_n);
                end
                base_next     = base_eff;
                reserved_next = reserved_eff;
                ram_rd_addr   = ptr_add(base_eff, PTR_W'(src_reg));
                if (32'(src_reg) < 32'(reserved_eff)) begin
                    ram_rd_en = 1'b1;
                end else begin
                    st_next.underrun = 1'b1;
                end
                // Step the phase; the source index follows floor(2p/3)
                if (32'(phase_reg) >= OUT_BLOCK - 1) begin
                    st_next.block_end = 1'b1;
                    phase_next    = '0;
                    reserved_next = '0;
                    src_next      = '0;
                    ph3_next      = PH3_0;
                end else begin
                    phase_next = phase_reg + PH_W'(1);
                    case (ph3_reg)
                        PH3_0: begin
                            ph3_next = PH3_1;
                        end
                        PH3_1: begin
                            ph3_next = PH3_2;
                            src_next = src_reg + SRC_W'(1);
                        end
                        default: begin
                            ph3_next = PH3_0;
                            src_next = src_reg + SRC_W'(1);
                        end
                    endcase
                end
            end
            st_next.fbuf = FBUF_W'(queued_next);
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg    <= RESET_LIMIT;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            queued_reg   <= '0;
            reserved_reg <= '0;
            base_reg     <= '0;
            phase_reg    <= '0;
            src_reg      <= '0;
            ph3_reg      <= PH3_0;
            acc_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            queued_reg   <= queued_next;
            reserved_reg <= reserved_next;
            base_reg     <= base_next;
            phase_reg    <= phase_next;
            src_reg      <= src_next;
            ph3_reg      <= ph3_next;
            acc_reg      <= acc_next;
        end
    end

    // Store stage: hold while the output register is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (s_tready) begin
            st_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            st_reg <= st_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (st_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_adv) begin
            if (st_reg.tick && !st_reg.underrun) begin
                m_left_reg  <= ram_rd_data[SAMPLE_W-1:0];
                m_right_reg <= ram_rd_data[FRAME_W-1:SAMPLE_W];
            end else begin
                m_left_reg  <= '0;
                m_right_reg <= '0;
            end
            m_under_reg <= st_reg.underrun;
            m_end_reg   <= st_reg.block_end;
            m_drop_reg  <= st_reg.dropped;
            m_fbuf_reg  <= st_reg.fbuf;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_fbuf_reg, m_right_reg, m_left_reg};
    assign m_tuser  = {m_drop_reg, m_under_reg};
    assign m_tlast  = m_end_reg;

    // Frame store
    afu_ram #(
        .DATA_W (FRAME_W),
        .DEPTH  (FIFO_FRAMES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (s_tdata),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking bench for the stereo frame FIFO with 2-to-3 upsampler.
// Predicts every result item from its own model of queue, block and call state.
// Depends on afu_pkg and the audio_frame_fifo_upsampler RTL.
`default_nettype none

module tb_top
    import afu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int HOLDOFF_CYCLES  = 400;

    typedef struct {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       start;
    } stim_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       under;
        logic                       bend;
        logic                       drop;
        logic [FBUF_W-1:0]          fbuf;
    } frame_res_t;

    // Clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // Block ports
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata     = '0;   // [15:0] sample_left, [31:16] sample_right
    logic [1:0]          s_tuser     = '0;   // [0] command, [1] call_start
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [47:0]         m_tdata;            // [15:0] left, [31:16] right, [45:32] buffered
    logic [1:0]          m_tuser;            // [0] underrun, [1] dropped
    logic                m_tlast;
    logic                cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0]  cfg_wr_data = '0;

    // Bench bookkeeping
    stim_t      pending_items[$];
    frame_res_t expected_frames[$];
    stim_t      on_bus;
    int         items_in     = 0;
    int         mismatches   = 0;
    int         cycle_no     = 0;
    int         quiet_cycles = 0;

    // Upsampler model state
    logic [FRAME_W-1:0] frame_mem [FIFO_FRAMES];
    int wr_ptr, rd_ptr, queued, reserved, base, phase, limit_m;
    logic call_ok;

    audio_frame_fifo_upsampler dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // No random gaps or stalls on either side inside this window; the hold-offs still apply
    function automatic logic calm_window();
        return (cycle_no >= 1200) && (cycle_no < 2700);
    endfunction

    // Advance the model by one accepted item and return the frame it causes
    function automatic frame_res_t upsample_step(stim_t it);
        frame_res_t r;
        int take;
        int src_idx;
        r = '{default: '0};
        if (it.cmd == CMD_PUSH) begin
            if (it.start) begin
                call_ok = (queued < limit_m);
            end
            if (!call_ok || (queued + reserved >= FIFO_FRAMES)) begin
                r.drop = 1'b1;
            end else begin
                frame_mem[wr_ptr] = {it.right, it.left};
                wr_ptr = (wr_ptr + 1) % FIFO_FRAMES;
                queued++;
            end
        end else begin
            // Reserve source frames at the start of each output block
            if (phase == 0) begin
                take     = (queued < SRC_BLOCK) ? queued : SRC_BLOCK;
                base     = rd_ptr;
                rd_ptr   = (rd_ptr + take) % FIFO_FRAMES;
                queued   = queued - take;
                reserved = take;
            end
            src_idx = (2 * phase) / 3;
            if (src_idx < reserved) begin
                {r.right, r.left} = frame_mem[(base + src_idx) % FIFO_FRAMES];
            end else begin
                r.under = 1'b1;
            end
            if (phase == OUT_BLOCK - 1) begin
                r.bend   = 1'b1;
                phase    = 0;
                reserved = 0;
            end else begin
                phase++;
            end
        end
        r.fbuf = FBUF_W'(queued);
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void add_item(logic cmd, logic [15:0] l, logic [15:0] r, logic st);
        stim_t it;
        it.cmd   = cmd;
        it.left  = l;
        it.right = r;
        it.start = st;
        pending_items.push_back(it);
    endfunction

    // One play call: a start frame followed by any further frames of the same call
    function automatic void add_call(int n);
        for (int i = 0; i < n; i++) begin
            add_item(CMD_PUSH, rand_sample(), rand_sample(), i == 0);
        end
    endfunction

    // Ticks carry random push fields, which the block must ignore
    function automatic void add_ticks(int n);
        for (int i = 0; i < n; i++) begin
            add_item(CMD_TICK, rand_sample(), rand_sample(), 1'($urandom_range(0, 1)));
        end
    endfunction

    // Mostly whole calls and tick bursts, with some stray pushes and noise
    function automatic void add_traffic(int n);
        int sel;
        int start_size;
        start_size = pending_items.size();
        while (pending_items.size() - start_size < n) begin
            sel = $urandom_range(0, 99);
            if (sel < 50) begin
                add_call($urandom_range(1, 64));
            end else if (sel < 85) begin
                add_ticks($urandom_range(1, 200));
            end else if (sel < 93) begin
                repeat ($urandom_range(1, 5)) add_item(CMD_PUSH, rand_sample(), rand_sample(), 1'b0);
            end else begin
                add_item(1'($urandom_range(0, 1)), rand_sample(), rand_sample(),
                         1'($urandom_range(0, 1)));
            end
        end
    endfunction

    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_frames.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(int value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= LIMIT_W'(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        limit_m = value;
    endtask

    task automatic report(string what, int want, int got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endtask

    // Driver: hold an item until accepted, then present the next one
    always @(posedge aclk) begin : drive_proc
        stim_t nxt;
        logic  gap;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_frames.push_back(upsample_step(on_bus));
                items_in++;
            end
            if (!s_tvalid || s_tready) begin
                gap = !calm_window() && ($urandom_range(0, 99) < 18);
                if (pending_items.size() != 0 && !gap) begin
                    nxt      = pending_items.pop_front();
                    on_bus   = nxt;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {nxt.right, nxt.left};
                    s_tuser  <= {nxt.start, nxt.cmd};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls plus two long hold-offs to back the block up
    always @(posedge aclk) begin : sink_proc
        int holdoff_left;
        int holdoffs_fired;
        if (!aresetn) begin
            m_tready       <= 1'b0;
            holdoff_left   = 0;
            holdoffs_fired = 0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            m_tready <= 1'b0;
        end else if ((holdoffs_fired == 0 && items_in >= 600) ||
                     (holdoffs_fired == 1 && items_in >= 1100)) begin
            holdoffs_fired++;
            holdoff_left = HOLDOFF_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm_window() || ($urandom_range(0, 99) >= 18);
        end
    end

    // Monitor: compare each result item with the oldest prediction
    always @(posedge aclk) begin : check_proc
        frame_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_frames.size() == 0) begin
                report("unexpected result item, data", 0, int'(m_tdata[31:0]));
            end else begin
                want = expected_frames.pop_front();
                if (m_tdata[15:0] !== want.left)
                    report("out_left", want.left, $signed(m_tdata[15:0]));
                if (m_tdata[31:16] !== want.right)
                    report("out_right", want.right, $signed(m_tdata[31:16]));
                if (m_tdata[45:32] !== want.fbuf)
                    report("frames_buffered", want.fbuf, m_tdata[45:32]);
                if (m_tuser[0] !== want.under)
                    report("underrun", want.under, m_tuser[0]);
                if (m_tuser[1] !== want.drop)
                    report("dropped", want.drop, m_tuser[1]);
                if (m_tlast !== want.bend)
                    report("block_end", want.bend, m_tlast);
            end
        end
    end

    // Watchdog: end the run if work is outstanding but nothing moves
    always @(posedge aclk) begin
        cycle_no++;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (pending_items.size() == 0 && !s_tvalid && expected_frames.size() == 0)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stim_proc
        // Model reset state
        wr_ptr   = 0;
        rd_ptr   = 0;
        queued   = 0;
        reserved = 0;
        base     = 0;
        phase    = 0;
        call_ok  = 1'b0;
        limit_m  = int'(RESET_LIMIT);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: stray push after reset, underrun, sample extremes, ignored fields
        add_item(CMD_PUSH, 16'h8000, 16'h7FFF, 1'b0);
        add_item(CMD_TICK, 16'h0000, 16'h0000, 1'b0);
        add_item(CMD_PUSH, 16'h7FFF, 16'h8000, 1'b1);
        add_item(CMD_PUSH, 16'hFFFF, 16'h0000, 1'b0);
        add_item(CMD_PUSH, 16'h0000, 16'hFFFF, 1'b0);
        add_item(CMD_TICK, 16'hFFFF, 16'hFFFF, 1'b1);
        add_item(CMD_PUSH, 16'h5555, 16'hAAAA, 1'b1);
        add_item(CMD_TICK, 16'hAAAA, 16'h5555, 1'b0);
        add_ticks(4);
        wait_idle();

        // Zero limit rejects every call
        write_limit(0);
        add_call(3);
        add_item(CMD_PUSH, 16'h1234, 16'h4321, 1'b0);
        add_traffic(150);
        wait_idle();

        write_limit(1);
        add_traffic(150);
        wait_idle();

        write_limit($urandom_range(2, 300));
        add_traffic(150);
        wait_idle();

        write_limit(8192);
        add_traffic(150);
        wait_idle();

        write_limit(6000);
        add_traffic(150);
        wait_idle();

        write_limit($urandom_range(0, 8192));
        add_traffic(150);
        wait_idle();

        // Long call from a block boundary, then drain it with ticks
        write_limit(8192);
        if (phase != 0) add_ticks(OUT_BLOCK - phase);
        add_call(100);
        add_ticks(150);
        wait_idle();

        repeat (10) @(posedge aclk);
        if (mismatches == 0 && expected_frames.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
